>>> sv/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and constants for the decimal integer pair parser.
// ----------------------------------------------------------------------------
package dip_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

  localparam int MAX_FIELD_CHARS_DEF = 11;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // largest magnitude that may still take one more digit
  localparam logic [31:0] MAG_LIMIT = 32'd214748364;
  localparam logic [3:0]  LAST_POS  = 4'd7;
  localparam logic [3:0]  LAST_NEG  = 4'd8;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] lead_value;
    logic signed [31:0] tail_value;
  } res_t;

endpackage

>>> sv/dip_if.sv
// ----------------------------------------------------------------------------
// dip_if
// Valid/ready channels for character words and parse result words.
// ----------------------------------------------------------------------------
interface dip_char_if
  import dip_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface dip_result_if
  import dip_pkg::*;
();
  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [31:0] lead_value;
  logic signed [31:0] tail_value;

  modport source (output valid, output status, output lead_value, output tail_value,
                  input ready);
  modport sink   (input valid, input status, input lead_value, input tail_value,
                  output ready);
endinterface

>>> sv/decimal_int32_pair_parser_unit.sv
// ----------------------------------------------------------------------------
// decimal_int32_pair_parser_unit
// Streaming ASCII decimal parser for one signed 32-bit integer or a pair.
// ----------------------------------------------------------------------------
// Usage:
//   chars   : one ASCII character per word; a zero byte ends the string.
//   results : one word per ended string with status, first and second value.
//   cfg_wr_en/cfg_wr_data : sets pair mode (1) or single mode (0); any write
//     also drops the string in progress. Write only while idle.
// Throughput: one character per cycle while chars.ready is high. Each
//   character updates the field state in the cycle it is taken (one
//   multiply-by-ten shift-add and a compare).
// Result: the result word is registered; it goes to the result register
//   when that is free or being taken, else to the skid register.
// Stall: a result register plus a one-word skid register; characters keep
//   flowing while one result waits, and chars.ready drops only when both
//   hold a word.
// Reset: clears all parse state and the valid flags of both result registers, single mode.
// ----------------------------------------------------------------------------
module decimal_int32_pair_parser_unit
  import dip_pkg::*;
#(
  parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  dip_char_if.sink            chars,
  dip_result_if.source        results
);

  localparam int LEN_W = $clog2(MAX_FIELD_CHARS + 2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FIELD_CHARS);

  // parse state
  logic             pair_mode;
  logic             field_index;
  logic             field_start;
  logic             is_negative;
  logic [31:0]      accumulated_magnitude;
  status_t          field_error;
  logic             digits_seen;
  logic [LEN_W-1:0] field_length;
  status_t          held_first_status;
  logic [LEN_W-1:0] held_first_length;
  logic [31:0]      held_first_value;

  // output stage
  logic out_valid;
  logic skid_valid;
  res_t out_word;
  res_t skid_word;

  logic        in_fire;
  logic        res_fire;
  logic        is_term;
  logic        is_split;
  logic        is_digit;
  logic [3:0]  digit;
  logic [3:0]  last_digit;
  logic        overflow;
  logic [31:0] mag_next;
  status_t     cur_status;
  logic [31:0] cur_value;
  res_t        res_next;

  assign chars.ready = !skid_valid;
  assign in_fire     = chars.valid && chars.ready;
  assign res_fire    = results.valid && results.ready;

  assign is_term  = chars.char_code == CH_NUL;
  assign is_split = pair_mode && !field_index && chars.char_code == CH_COMMA;
  assign is_digit = chars.char_code >= CH_ZERO && chars.char_code <= CH_NINE;
  assign digit    = chars.char_code[3:0];

  assign last_digit = is_negative ? LAST_NEG : LAST_POS;
  assign overflow   = accumulated_magnitude > MAG_LIMIT ||
                      (accumulated_magnitude == MAG_LIMIT && digit > last_digit);
  assign mag_next   = (accumulated_magnitude << 3) + (accumulated_magnitude << 1) +
                      {28'd0, digit};

  always_comb begin
    if (field_error != ST_OK) begin
      cur_status = field_error;
    end else if (!digits_seen) begin
      cur_status = ST_INVALID;
    end else begin
      cur_status = ST_OK;
    end
    if (cur_status != ST_OK) begin
      cur_value = 32'd0;
    end else if (is_negative) begin
      cur_value = 32'd0 - accumulated_magnitude;
    end else begin
      cur_value = accumulated_magnitude;
    end
  end

  // result for a string ending now
  always_comb begin
    res_next.status     = ST_OK;
    res_next.lead_value = '0;
    res_next.tail_value = '0;
    if (!pair_mode) begin
      res_next.status     = cur_status;
      res_next.lead_value = cur_value;
    end else if (!field_index || held_first_length == '0 || field_length == '0) begin
      res_next.status = ST_INVALID;
    end else if (held_first_length > LEN_MAX || field_length > LEN_MAX) begin
      res_next.status = ST_RANGE;
    end else if (held_first_status != ST_OK) begin
      res_next.status = held_first_status;
    end else begin
      res_next.status = cur_status;
      if (cur_status == ST_OK) begin
        res_next.lead_value = held_first_value;
        res_next.tail_value = cur_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en || (in_fire && is_term)) begin
      if (rst) begin
        pair_mode <= 1'b0;
      end else if (cfg_wr_en) begin
        pair_mode <= cfg_wr_data;
      end
      field_index           <= 1'b0;
      field_start           <= 1'b1;
      is_negative           <= 1'b0;
      accumulated_magnitude <= '0;
      field_error           <= ST_OK;
      digits_seen           <= 1'b0;
      field_length          <= '0;
      held_first_status     <= ST_OK;
      held_first_length     <= '0;
      held_first_value      <= '0;
    end else if (in_fire && is_split) begin
      held_first_status     <= cur_status;
      held_first_length     <= field_length;
      held_first_value      <= cur_value;
      field_index           <= 1'b1;
      field_start           <= 1'b1;
      is_negative           <= 1'b0;
      accumulated_magnitude <= '0;
      field_error           <= ST_OK;
      digits_seen           <= 1'b0;
      field_length          <= '0;
    end else if (in_fire) begin
      // length saturates one past the limit
      if (field_length <= LEN_MAX) begin
        field_length <= field_length + 1'b1;
      end
      if (field_error == ST_OK) begin
        if (field_start && chars.char_code == CH_MINUS) begin
          is_negative <= 1'b1;
        end else if (field_start && chars.char_code == CH_PLUS) begin
          is_negative <= 1'b0;
        end else if (is_digit) begin
          if (overflow) begin
            field_error <= ST_RANGE;
          end else begin
            accumulated_magnitude <= mag_next;
            digits_seen           <= 1'b1;
          end
        end else begin
          field_error <= ST_INVALID;
        end
      end
      field_start <= 1'b0;
    end
  end

  // result register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res_fire) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_fire && is_term) begin
        out_word  <= res_next;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_fire && is_term) begin
      skid_word  <= res_next;
      skid_valid <= 1'b1;
    end
  end

  assign results.valid      = out_valid;
  assign results.status     = out_word.status;
  assign results.lead_value = out_word.lead_value;
  assign results.tail_value = out_word.tail_value;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without a result word in front");

  a_error_zero_values: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status != ST_OK |->
      results.lead_value == 32'sd0 && results.tail_value == 32'sd0)
    else $error("nonzero value on a failed parse");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_term |=> field_length == '0 && !field_index && field_start)
    else $error("parse state not cleared after end of string");

  a_term_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_term |=> out_valid)
    else $error("end of string produced no result word");
`endif

endmodule
